// ===== src/prqs_pkg.sv =====
// prqs_pkg: shared codes, widths and the cell control struct for the
// process ready queue scheduler. No dependencies.
`default_nettype none

package prqs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 8;
  localparam int TIME_WIDTH_DEF  = 16;
  localparam int PRIO_W          = 8;

  // request codes
  localparam logic [1:0] REQ_ENQ    = 2'd0;
  localparam logic [1:0] REQ_TAKE   = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_LOOKUP = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // scheduling policies; the unused code falls back to FIFO
  localparam logic [1:0] MODE_PRIO = 2'd0;
  localparam logic [1:0] MODE_SRTN = 2'd1;
  localparam logic [1:0] MODE_FIFO = 2'd2;

  typedef struct packed {
    logic       shift;   // close the gap at and above the selected slot
    logic       append;  // write the request entry at the slot == occupancy
    logic [1:0] req;     // request being searched for
    logic [1:0] mode;    // current policy
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/prqs_cell.sv =====
// prqs_cell: one queue slot plus one stage of the search chain.
// Depends on prqs_pkg.
`default_nettype none

module prqs_cell #(
  parameter int ID_W     = 8,
  parameter int TIME_W   = 16,
  parameter int IDX_W    = 4,
  parameter int OCC_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  wire                          clk,
  input  wire prqs_pkg::cell_ctrl_t    ctrl,
  input  wire [OCC_W-1:0]              occ,
  input  wire [IDX_W-1:0]              pos,
  input  wire [ID_W-1:0]               req_id,
  input  wire [prqs_pkg::PRIO_W-1:0]   req_prio,
  input  wire [TIME_W-1:0]             req_rem,
  // candidate from the left neighbor
  input  wire                          cin_found,
  input  wire [TIME_W-1:0]             cin_key,
  input  wire [IDX_W-1:0]              cin_pos,
  input  wire [ID_W-1:0]               cin_id,
  input  wire [prqs_pkg::PRIO_W-1:0]   cin_prio,
  input  wire [TIME_W-1:0]             cin_rem,
  // slot contents of the right neighbor, for compaction
  input  wire [ID_W-1:0]               nb_id,
  input  wire [prqs_pkg::PRIO_W-1:0]   nb_prio,
  input  wire [TIME_W-1:0]             nb_rem,
  // registered candidate to the right neighbor
  output logic                         cout_found,
  output logic [TIME_W-1:0]            cout_key,
  output logic [IDX_W-1:0]             cout_pos,
  output logic [ID_W-1:0]              cout_id,
  output logic [prqs_pkg::PRIO_W-1:0]  cout_prio,
  output logic [TIME_W-1:0]            cout_rem,
  // own slot, to the left neighbor
  output logic [ID_W-1:0]              slot_id,
  output logic [prqs_pkg::PRIO_W-1:0]  slot_prio,
  output logic [TIME_W-1:0]            slot_rem
);
  import prqs_pkg::*;

  logic [ID_W-1:0]   slot_id_r;
  logic [PRIO_W-1:0] slot_prio_r;
  logic [TIME_W-1:0] slot_rem_r;
  logic [TIME_W-1:0] own_key;
  logic              own_valid;
  logic              sel;

  always_comb begin
    case (ctrl.mode)
      MODE_PRIO: own_key = TIME_W'(slot_prio_r);
      MODE_SRTN: own_key = slot_rem_r;
      default:   own_key = '0;  // FIFO: first valid slot wins
    endcase
  end

  assign own_valid = OCC_W'(CELL_IDX) < occ;

  // strict less-than keeps the earlier entry on ties
  always_comb begin
    if (ctrl.req == REQ_TAKE) begin
      sel = own_valid && (!cin_found || (own_key < cin_key));
    end else begin
      sel = own_valid && !cin_found && (slot_id_r == req_id);
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      cout_found <= 1'b1;
      cout_key   <= own_key;
      cout_pos   <= IDX_W'(CELL_IDX);
      cout_id    <= slot_id_r;
      cout_prio  <= slot_prio_r;
      cout_rem   <= slot_rem_r;
    end else begin
      cout_found <= cin_found;
      cout_key   <= cin_key;
      cout_pos   <= cin_pos;
      cout_id    <= cin_id;
      cout_prio  <= cin_prio;
      cout_rem   <= cin_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift && (IDX_W'(CELL_IDX) >= pos)) begin
      slot_id_r   <= nb_id;
      slot_prio_r <= nb_prio;
      slot_rem_r  <= nb_rem;
    end else if (ctrl.append && (OCC_W'(CELL_IDX) == occ)) begin
      slot_id_r   <= req_id;
      slot_prio_r <= req_prio;
      slot_rem_r  <= req_rem;
    end
  end

  assign slot_id   = slot_id_r;
  assign slot_prio = slot_prio_r;
  assign slot_rem  = slot_rem_r;

endmodule

`default_nettype wire

// ===== src/process_ready_queue_scheduler.sv =====
// process_ready_queue_scheduler: top level; request control, chain of
// prqs_cell slots, result register. Depends on prqs_pkg and prqs_cell.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+-----------------
//   in      | in_req_type, in_proc_id, in_proc_*     | in_valid/in_ready
//   out     | out_status, out_id, out_priority,      | out_valid/out_ready
//           | out_remaining, out_entry_count         |
//   cfg     | cfg_sched_mode                         | cfg_we, no wait
//
// Flow: an enqueue goes from accept straight to the commit state, and its result is
//   registered when it commits; the next item is taken after the commit. Take,
//   remove and lookup first scan while the candidate walks the cell chain one
//   cell per cycle, then commit. One item is in flight at a time.
// Reset: rst_n synchronous; empties the queue and sets the policy to
//   lowest priority first. Slot contents are not cleared.
// Stalls: the result sits in the output register; a new item is taken while
//   it waits, and the next commit holds until the result is taken.
`default_nettype none

module process_ready_queue_scheduler #(
  parameter int QUEUE_DEPTH = prqs_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = prqs_pkg::ID_WIDTH_DEF,
  parameter int TIME_WIDTH  = prqs_pkg::TIME_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // configuration
  input  wire                                   cfg_we,
  input  wire [1:0]                             cfg_sched_mode,
  // request channel
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire [1:0]                             in_req_type,
  input  wire [ID_WIDTH-1:0]                    in_proc_id,
  input  wire [prqs_pkg::PRIO_W-1:0]            in_proc_priority,
  input  wire [TIME_WIDTH-1:0]                  in_proc_remaining,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [1:0]                            out_status,
  output logic [ID_WIDTH-1:0]                   out_id,
  output logic [prqs_pkg::PRIO_W-1:0]           out_priority,
  output logic [TIME_WIDTH-1:0]                 out_remaining,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      out_entry_count
);
  import prqs_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [1:0]        mode_r;
  logic [1:0]        req_r;
  logic [ID_WIDTH-1:0]   id_r;
  logic [PRIO_W-1:0]     prio_r;
  logic [TIME_WIDTH-1:0] rem_r;

  logic                  out_valid_r;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [ID_WIDTH-1:0]   out_id_r, out_id_nxt;
  logic [PRIO_W-1:0]     out_prio_r, out_prio_nxt;
  logic [TIME_WIDTH-1:0] out_rem_r, out_rem_nxt;
  logic [OCC_W-1:0]      out_cnt_r;

  logic       in_fire;
  logic       commit;
  cell_ctrl_t ctrl;

  // search chain: index 0 is the seed, QUEUE_DEPTH is the final candidate
  logic                  c_found [QUEUE_DEPTH+1];
  logic [TIME_WIDTH-1:0] c_key   [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]      c_pos   [QUEUE_DEPTH+1];
  logic [ID_WIDTH-1:0]   c_id    [QUEUE_DEPTH+1];
  logic [PRIO_W-1:0]     c_prio  [QUEUE_DEPTH+1];
  logic [TIME_WIDTH-1:0] c_rem   [QUEUE_DEPTH+1];

  logic [ID_WIDTH-1:0]   s_id   [QUEUE_DEPTH];
  logic [PRIO_W-1:0]     s_prio [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] s_rem  [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0]   n_id   [QUEUE_DEPTH];
  logic [PRIO_W-1:0]     n_prio [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] n_rem  [QUEUE_DEPTH];

  assign c_found[0] = 1'b0;
  assign c_key[0]   = '0;
  assign c_pos[0]   = '0;
  assign c_id[0]    = '0;
  assign c_prio[0]  = '0;
  assign c_rem[0]   = '0;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      if (gi < QUEUE_DEPTH - 1) begin : g_nb
        assign n_id[gi]   = s_id[gi+1];
        assign n_prio[gi] = s_prio[gi+1];
        assign n_rem[gi]  = s_rem[gi+1];
      end else begin : g_top
        // top slot after a removal is beyond occupancy; contents don't matter
        assign n_id[gi]   = '0;
        assign n_prio[gi] = '0;
        assign n_rem[gi]  = '0;
      end

      prqs_cell #(
        .ID_W     (ID_WIDTH),
        .TIME_W   (TIME_WIDTH),
        .IDX_W    (IDX_W),
        .OCC_W    (OCC_W),
        .CELL_IDX (gi)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (occ_r),
        .pos        (c_pos[QUEUE_DEPTH]),
        .req_id     (id_r),
        .req_prio   (prio_r),
        .req_rem    (rem_r),
        .cin_found  (c_found[gi]),
        .cin_key    (c_key[gi]),
        .cin_pos    (c_pos[gi]),
        .cin_id     (c_id[gi]),
        .cin_prio   (c_prio[gi]),
        .cin_rem    (c_rem[gi]),
        .nb_id      (n_id[gi]),
        .nb_prio    (n_prio[gi]),
        .nb_rem     (n_rem[gi]),
        .cout_found (c_found[gi+1]),
        .cout_key   (c_key[gi+1]),
        .cout_pos   (c_pos[gi+1]),
        .cout_id    (c_id[gi+1]),
        .cout_prio  (c_prio[gi+1]),
        .cout_rem   (c_rem[gi+1]),
        .slot_id    (s_id[gi]),
        .slot_prio  (s_prio[gi]),
        .slot_rem   (s_rem[gi])
      );
    end
  endgenerate

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  // commit waits only if the previous result is still unclaimed
  assign commit   = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // next state and counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_nxt   = '0;
          state_nxt = (in_req_type == REQ_ENQ) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // the scan ends once every cell has seen a settled candidate
        if (cnt_r == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result and queue update; take, remove and lookup use the chain's final candidate
  always_comb begin
    ctrl.shift     = 1'b0;
    ctrl.append    = 1'b0;
    ctrl.req       = req_r;
    ctrl.mode      = mode_r;
    occ_nxt        = occ_r;
    out_status_nxt = STAT_OK;
    out_id_nxt     = '0;
    out_prio_nxt   = '0;
    out_rem_nxt    = '0;
    case (req_r)
      REQ_ENQ: begin
        if (occ_r == OCC_W'(QUEUE_DEPTH)) begin
          out_status_nxt = STAT_FULL;
        end else begin
          ctrl.append = commit;
          occ_nxt     = occ_r + OCC_W'(1);
        end
      end
      REQ_TAKE: begin
        if (occ_r == '0) begin
          out_status_nxt = STAT_EMPTY;
        end else begin
          ctrl.shift   = commit;
          occ_nxt      = occ_r - OCC_W'(1);
          out_id_nxt   = c_id[QUEUE_DEPTH];
          out_prio_nxt = c_prio[QUEUE_DEPTH];
          out_rem_nxt  = c_rem[QUEUE_DEPTH];
        end
      end
      REQ_REMOVE, REQ_LOOKUP: begin
        if (!c_found[QUEUE_DEPTH]) begin
          out_status_nxt = STAT_NOTFOUND;
        end else begin
          if (req_r == REQ_REMOVE) begin
            ctrl.shift = commit;
            occ_nxt    = occ_r - OCC_W'(1);
          end
          out_id_nxt   = c_id[QUEUE_DEPTH];
          out_prio_nxt = c_prio[QUEUE_DEPTH];
          out_rem_nxt  = c_rem[QUEUE_DEPTH];
        end
      end
      default: out_status_nxt = STAT_OK;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      occ_r       <= '0;
      mode_r      <= MODE_PRIO;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        mode_r <= cfg_sched_mode;
      end
      if (commit) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r  <= in_req_type;
      id_r   <= in_proc_id;
      prio_r <= in_proc_priority;
      rem_r  <= in_proc_remaining;
    end
    if (commit) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= out_id_nxt;
      out_prio_r   <= out_prio_nxt;
      out_rem_r    <= out_rem_nxt;
      out_cnt_r    <= occ_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_id          = out_id_r;
  assign out_priority    = out_prio_r;
  assign out_remaining   = out_rem_r;
  assign out_entry_count = out_cnt_r;

  // occupancy is bounded by the slot count
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  // the queue only changes on a commit
  a_occ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(commit)) |-> $stable(occ_r))
    else $error("occupancy changed outside a commit");

  // a full drop reports a full queue, an empty take an empty one
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_FULL) |-> out_cnt_r == OCC_W'(QUEUE_DEPTH))
    else $error("full status with queue not full");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_EMPTY) |-> out_cnt_r == '0)
    else $error("empty status with entries queued");

  // a new result only follows a commit
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the commit state");

endmodule

`default_nettype wire
